// ----- hdl/wildcard_pattern_matcher_top_defines.svh -----
// Assertion macros shared by the wildcard pattern matcher RTL.
// No dependencies; included by the modules that carry checks.
`ifndef WILDCARD_PATTERN_MATCHER_TOP_DEFINES_SVH
`define WILDCARD_PATTERN_MATCHER_TOP_DEFINES_SVH

// Condition holds at every edge out of reset.
`define WPM_ASSERT_ALWAYS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("wpm: invariant violated");

// Consequent holds in the cycle after the antecedent.
`define WPM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("wpm: next-cycle check failed");

`endif

// ----- hdl/wpm_pkg.sv -----
// Shared constants, op codes and queue entry type for the wildcard matcher.
// No dependencies; imported by every module of the block.
`default_nettype none

package wpm_pkg;

    localparam int MAX_PATTERN = 64;
    localparam int NPOS        = MAX_PATTERN + 1;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int ADDR_W      = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int SYM_W       = 8;
    localparam int CMD_W       = 2;

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [SYM_W-1:0] SYM_STAR     = 8'd42;
    localparam logic [SYM_W-1:0] SYM_QUESTION = 8'd63;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TEXT   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_END    = 2'd3;

    typedef enum logic [2:0] {
        OP_CLEAR,
        OP_STORE,
        OP_DROP,
        OP_TEXT,
        OP_END
    } op_kind_t;

    typedef struct packed {
        op_kind_t           kind;
        logic [SYM_W-1:0]   sym;
        logic               is_star;
        logic               is_quest;
        logic [LEN_W-1:0]   len;
    } op_t;

endpackage

`default_nettype wire

// ----- hdl/wpm_front.sv -----
// Front end: accepts input beats, tracks pattern length and classifies ops.
// Depends on wpm_pkg; feeds wpm_queue.
`default_nettype none
`include "wildcard_pattern_matcher_top_defines.svh"

module wpm_front
    import wpm_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [CMD_W-1:0]   in_cmd,
    input  wire logic [SYM_W-1:0]   in_sym,
    input  wire logic               q_ready,
    output logic                    q_push,
    output op_t                     q_op
);

    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic             full;

    assign in_ready = q_ready;
    assign q_push   = in_valid & q_ready;
    assign full     = (len_reg == LEN_W'(MAX_PATTERN));

    always_comb begin
        q_op.sym      = in_sym;
        q_op.is_star  = (in_sym == SYM_STAR);
        q_op.is_quest = (in_sym == SYM_QUESTION);
        q_op.len      = len_reg;
        len_next      = len_reg;
        unique case (in_cmd)
            CMD_CLEAR: begin
                q_op.kind = OP_CLEAR;
                len_next  = '0;
            end
            CMD_APPEND: begin
                if (full) begin
                    q_op.kind = OP_DROP;
                end else begin
                    q_op.kind = OP_STORE;
                    len_next  = len_reg + LEN_W'(1);
                end
            end
            CMD_TEXT: q_op.kind = OP_TEXT;
            default:  q_op.kind = OP_END;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
        end else if (q_push) begin
            len_reg <= len_next;
        end
    end

    `WPM_ASSERT_ALWAYS(a_len_bound, aclk, aresetn, len_reg <= LEN_W'(MAX_PATTERN))

endmodule

`default_nettype wire

// ----- hdl/wpm_queue.sv -----
// Short FIFO of classified ops between front and back end.
// Depends on wpm_pkg.
`default_nettype none
`include "wildcard_pattern_matcher_top_defines.svh"

module wpm_queue
    import wpm_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   push,
    input  wire op_t    push_op,
    output logic        ready,
    input  wire logic   pop,
    output logic        head_valid,
    output op_t         head_op
);

    op_t               mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_reg;
    logic [QPTR_W-1:0] rd_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;
    logic              do_pop;

    assign ready      = (cnt_reg != QCNT_W'(QDEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_op    = mem_reg[rd_reg];
    assign do_pop     = pop & head_valid;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !do_pop) begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end else if (do_pop && !push) begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= push_op;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_reg <= wr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_reg <= rd_reg + QPTR_W'(1);
            end
        end
    end

    `WPM_ASSERT_ALWAYS(a_cnt_bound, aclk, aresetn, cnt_reg <= QCNT_W'(QDEPTH))

endmodule

`default_nettype wire

// ----- hdl/wpm_back.sv -----
// Back end: pattern store, position-set automaton and result register.
// Depends on wpm_pkg; consumes ops from wpm_queue.
`default_nettype none
`include "wildcard_pattern_matcher_top_defines.svh"

module wpm_back
    import wpm_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   op_valid,
    input  wire op_t    op,
    output logic        op_pop,
    output logic        res_valid,
    input  wire logic   res_ready,
    output logic        res_matched,
    output logic        res_overflow
);

    logic [SYM_W-1:0]       sym_reg [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] star_reg;
    logic [MAX_PATTERN-1:0] quest_reg;
    logic [NPOS-1:0]        act_reg;
    logic [NPOS-1:0]        act_next;
    logic [NPOS-1:0]        lead_reg;
    logic [NPOS-1:0]        lead_next;
    logic                   ovf_reg;
    logic                   ovf_next;
    logic                   res_valid_reg;
    logic                   res_match_reg;
    logic                   res_ovf_reg;

    logic [MAX_PATTERN-1:0] in_pat;
    logic [NPOS-1:0]        gen;
    logic [NPOS-1:0]        prop;
    logic [NPOS-1:0]        g_lv [LEN_W+1];
    logic [NPOS-1:0]        p_lv [LEN_W+1];
    logic                   is_end;

    assign is_end       = (op.kind == OP_END);
    assign op_pop       = op_valid & (!is_end | !res_valid_reg | res_ready);
    assign res_valid    = res_valid_reg;
    assign res_matched  = res_match_reg;
    assign res_overflow = res_ovf_reg;

    // next active set before star closure
    always_comb begin
        gen  = '0;
        prop = '0;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            in_pat[i] = (LEN_W'(i) < op.len);
        end
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (act_reg[i] && in_pat[i]) begin
                if (star_reg[i]) begin
                    gen[i] = 1'b1;
                end
                if (quest_reg[i] || (sym_reg[i] == op.sym)) begin
                    gen[i+1] = 1'b1;
                end
            end
            prop[i+1] = in_pat[i] & star_reg[i];
        end
    end

    // star closure as a parallel prefix over positions
    always_comb begin
        g_lv[0] = gen;
        p_lv[0] = prop;
        for (int lv = 0; lv < LEN_W; lv++) begin
            for (int j = 0; j < NPOS; j++) begin
                if (j >= (1 << lv)) begin
                    g_lv[lv+1][j] = g_lv[lv][j] | (p_lv[lv][j] & g_lv[lv][j-(1<<lv)]);
                    p_lv[lv+1][j] = p_lv[lv][j] & p_lv[lv][j-(1<<lv)];
                end else begin
                    g_lv[lv+1][j] = g_lv[lv][j];
                    p_lv[lv+1][j] = p_lv[lv][j];
                end
            end
        end
    end

    always_comb begin
        lead_next = lead_reg;
        act_next  = act_reg;
        ovf_next  = ovf_reg;
        if (op_pop) begin
            unique case (op.kind)
                OP_CLEAR: begin
                    lead_next = NPOS'(1);
                    ovf_next  = 1'b0;
                    act_next  = NPOS'(1);
                end
                OP_STORE: begin
                    for (int j = 1; j < NPOS; j++) begin
                        lead_next[j] = lead_reg[j] |
                            (lead_reg[j-1] & op.is_star & (op.len == LEN_W'(j - 1)));
                    end
                    act_next = lead_next;
                end
                OP_DROP: begin
                    ovf_next = 1'b1;
                    act_next = lead_reg;
                end
                OP_TEXT: act_next = g_lv[LEN_W];
                OP_END:  act_next = lead_reg;
                default: act_next = act_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (op_pop && op.kind == OP_STORE) begin
            sym_reg[op.len[ADDR_W-1:0]]   <= op.sym;
            star_reg[op.len[ADDR_W-1:0]]  <= op.is_star;
            quest_reg[op.len[ADDR_W-1:0]] <= op.is_quest;
        end
        if (op_pop && is_end) begin
            res_match_reg <= act_reg[op.len];
            res_ovf_reg   <= ovf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg       <= NPOS'(1);
            lead_reg      <= NPOS'(1);
            ovf_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            act_reg  <= act_next;
            lead_reg <= lead_next;
            ovf_reg  <= ovf_next;
            if (op_pop && is_end) begin
                res_valid_reg <= 1'b1;
            end else if (res_ready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    `WPM_ASSERT_ALWAYS(a_lead_base, aclk, aresetn, lead_reg[0])
    `WPM_ASSERT_NEXT(a_end_restart, aclk, aresetn, op_pop && is_end, act_reg == lead_reg)
    `WPM_ASSERT_NEXT(a_drop_sticky, aclk, aresetn, op_pop && op.kind == OP_DROP, ovf_reg)
    `WPM_ASSERT_NEXT(a_end_result, aclk, aresetn, op_pop && is_end, res_valid_reg)

endmodule

`default_nettype wire

// ----- hdl/wildcard_pattern_matcher_top.sv -----
// Top level of the wildcard pattern matcher: front end, op queue, back end.
// Depends on wpm_pkg, wpm_front, wpm_queue and wpm_back.
//
// Usage:
//   Input stream s_*: one beat per command. Clear and append build the pattern
//   ('*' any run, '?' any one byte, up to MAX_PATTERN bytes; more set a sticky
//   overflow flag). Text beats feed the text; end of text yields one result.
//   Output stream m_*: one beat per end of text, carrying matched and overflow.
// Throughput: one beat per cycle while the op queue has room, set by the
//   position-set update in the back end (all pattern positions compared and star-closed at once).
// Result path: an accepted end-of-text beat is stored in the op queue, then
//   its result is taken into the result register that drives m_tvalid.
// Reset: aresetn low clears the pattern length, overflow flag, active set and
//   the queue; the pattern is empty after reset.
// Stall: while m_tready is low a pending result holds; the back end keeps
//   taking non-result ops, and s_tready drops only once the four-entry queue
//   is full.
`default_nettype none

module wildcard_pattern_matcher_top
    import wpm_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] symbol
    input  wire logic [1:0]  s_tuser,   // [1:0] command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata    // [0] matched, [1] pattern_overflow, rest zero
);

    logic q_ready;
    logic q_push;
    op_t  q_op;
    logic head_valid;
    op_t  head_op;
    logic pop;
    logic matched;
    logic overflow;

    wpm_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_cmd   (s_tuser),
        .in_sym   (s_tdata),
        .q_ready  (q_ready),
        .q_push   (q_push),
        .q_op     (q_op)
    );

    wpm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_op    (q_op),
        .ready      (q_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head_op    (head_op)
    );

    wpm_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .op_valid     (head_valid),
        .op           (head_op),
        .op_pop       (pop),
        .res_valid    (m_tvalid),
        .res_ready    (m_tready),
        .res_matched  (matched),
        .res_overflow (overflow)
    );

    assign m_tdata = {6'b0, overflow, matched};

endmodule

`default_nettype wire

// ----- test/wpm_match_checker.sv -----
`timescale 1ns / 100ps
// Watches both streams of the wildcard pattern matcher, predicts each result and compares it.
// Depends on wpm_pkg for widths, command codes and the wildcard symbols.

module wpm_match_checker
    import wpm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic matched;
        logic overflow;
    } match_result_t;

    match_result_t    expected_results[$];
    logic [SYM_W-1:0] pat_mem [MAX_PATTERN];
    int               pat_len;
    logic             pat_overflow;
    logic [NPOS-1:0]  live_pos;

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic logic [NPOS-1:0] close_over_stars(logic [NPOS-1:0] pos_set);
        for (int i = 0; i < pat_len; i++) begin
            if (pos_set[i] && pat_mem[i] == SYM_STAR)
                pos_set[i+1] = 1'b1;
        end
        return pos_set;
    endfunction

    task automatic predict_beat(logic [CMD_W-1:0] cmd, logic [SYM_W-1:0] sym);
        logic [NPOS-1:0] next_pos;
        match_result_t   res;
        case (cmd)
            CMD_CLEAR: begin
                pat_len      = 0;
                pat_overflow = 1'b0;
                live_pos     = close_over_stars(NPOS'(1));
            end
            CMD_APPEND: begin
                if (pat_len < MAX_PATTERN) begin
                    pat_mem[pat_len] = sym;
                    pat_len++;
                end else begin
                    pat_overflow = 1'b1;
                end
                live_pos = close_over_stars(NPOS'(1));
            end
            CMD_TEXT: begin
                next_pos = '0;
                for (int i = 0; i < pat_len; i++) begin
                    if (live_pos[i]) begin
                        if (pat_mem[i] == SYM_STAR)
                            next_pos[i] = 1'b1;
                        if (pat_mem[i] == sym || pat_mem[i] == SYM_QUESTION)
                            next_pos[i+1] = 1'b1;
                    end
                end
                live_pos = close_over_stars(next_pos);
            end
            default: begin
                res.matched  = live_pos[pat_len];
                res.overflow = pat_overflow;
                expected_results.push_back(res);
                live_pos = close_over_stars(NPOS'(1));
            end
        endcase
    endtask

    always @(posedge aclk) begin
        match_result_t exp_res;
        if (!aresetn) begin
            pat_len      = 0;
            pat_overflow = 1'b0;
            live_pos     = NPOS'(1);
            expected_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result beat: m_tdata=%h", m_tdata);
                    fail_count++;
                end else begin
                    exp_res = expected_results.pop_front();
                    if (m_tdata[0] !== exp_res.matched) begin
                        $error("matched: expected %0b, actual %0b", exp_res.matched, m_tdata[0]);
                        fail_count++;
                    end
                    if (m_tdata[1] !== exp_res.overflow) begin
                        $error("pattern_overflow: expected %0b, actual %0b",
                               exp_res.overflow, m_tdata[1]);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict_beat(s_tuser, s_tdata);
        end
        pending = expected_results.size();
    end

endmodule

// ----- test/tb_wildcard_pattern_matcher_top.sv -----
`timescale 1ns / 100ps
// Testbench top for wildcard_pattern_matcher_top: clock, reset, command stimulus and verdict.
// Depends on wpm_pkg, the block under test and wpm_match_checker.

module tb_wildcard_pattern_matcher_top;
    import wpm_pkg::*;

    localparam int N_ITEMS        = 1700;
    localparam int CALM_AFTER     = 1450;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam logic [7:0] CH_A = 8'h61;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;

    int fail_count;
    int pending;
    int items_sent      = 0;
    int idle_cycles     = 0;
    int rx_gap          = 0;
    int long_hold_count = 0;
    bit tx_idle         = 1'b1;
    bit rx_idle         = 1'b1;
    bit long_hold_req   = 1'b0;
    bit long_hold_done  = 1'b0;

    logic [7:0] pattern_q[$];
    bit         pattern_known;

    wildcard_pattern_matcher_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    wpm_match_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        if (long_hold_req && !long_hold_done) begin
            m_tready <= 1'b0;
            if (long_hold_count == LONG_HOLD)
                long_hold_done <= 1'b1;
            long_hold_count <= long_hold_count + 1;
        end else if (rx_gap > 0) begin
            m_tready <= 1'b0;
            rx_gap   <= rx_gap - 1;
        end else if (rx_idle && $urandom_range(0, 5) == 0) begin
            m_tready <= 1'b0;
            rx_gap   <= $urandom_range(0, 9);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic send_beat(logic [CMD_W-1:0] cmd, logic [SYM_W-1:0] sym);
        if (tx_idle && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sym;
        s_tuser  <= cmd;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        items_sent++;
    endtask

    function automatic logic [7:0] pick_pattern_sym();
        int r;
        r = $urandom_range(0, 19);
        if (r < 4)       return SYM_STAR;
        else if (r < 7)  return SYM_QUESTION;
        else if (r < 18) return CH_A + 8'($urandom_range(0, 2));
        else             return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_text_sym();
        int r;
        r = $urandom_range(0, 19);
        if (r < 2)       return SYM_STAR;
        else if (r < 17) return CH_A + 8'($urandom_range(0, 2));
        else             return 8'($urandom_range(0, 255));
    endfunction

    // Build a text that fits the held pattern, optionally break it, then end it.
    task automatic send_text(bit want_match);
        logic [7:0] txt[$];
        int         idx;
        foreach (pattern_q[i]) begin
            if (pattern_q[i] == SYM_STAR) begin
                repeat ($urandom_range(0, 3)) txt.push_back(pick_text_sym());
            end else if (pattern_q[i] == SYM_QUESTION) begin
                txt.push_back(8'($urandom_range(0, 255)));
            end else begin
                txt.push_back(pattern_q[i]);
            end
        end
        if (!want_match) begin
            idx = (txt.size() == 0) ? 0 : $urandom_range(0, txt.size() - 1);
            case ($urandom_range(0, 2))
                0: txt.insert(idx, pick_text_sym());
                1: if (txt.size() > 0) txt.delete(idx);
                default: if (txt.size() > 0) txt[idx] = pick_text_sym();
            endcase
        end
        foreach (txt[i]) send_beat(CMD_TEXT, txt[i]);
        send_beat(CMD_END, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_sequence();
        int plen;
        logic [7:0] psym;
        if (!pattern_known || $urandom_range(0, 4) != 0) begin
            send_beat(CMD_CLEAR, 8'($urandom_range(0, 255)));
            pattern_q.delete();
            pattern_known = 1'b1;
        end
        plen = ($urandom_range(0, 14) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 8);
        repeat (plen) begin
            psym = pick_pattern_sym();
            send_beat(CMD_APPEND, psym);
            if (pattern_q.size() < MAX_PATTERN)
                pattern_q.push_back(psym);
        end
        repeat ($urandom_range(1, 4)) send_text($urandom_range(0, 1));
    endtask

    initial begin
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_beat(CMD_END, 8'h00);
        send_beat(CMD_TEXT, CH_A);
        send_beat(CMD_END, 8'hff);
        send_beat(CMD_APPEND, SYM_STAR);
        send_beat(CMD_END, 8'h00);
        send_beat(CMD_APPEND, CH_A);
        send_beat(CMD_APPEND, SYM_QUESTION);
        send_beat(CMD_APPEND, SYM_STAR);
        send_beat(CMD_TEXT, SYM_STAR);
        send_beat(CMD_TEXT, CH_A);
        send_beat(CMD_TEXT, 8'hff);
        send_beat(CMD_END, 8'h00);
        send_beat(CMD_TEXT, CH_A);
        send_beat(CMD_APPEND, 8'h00);
        send_beat(CMD_TEXT, CH_A);
        send_beat(CMD_TEXT, SYM_STAR);
        send_beat(CMD_TEXT, 8'h00);
        send_beat(CMD_END, 8'h00);
        send_beat(CMD_CLEAR, 8'hff);
        send_beat(CMD_APPEND, 8'hff);
        send_beat(CMD_APPEND, SYM_STAR);
        send_beat(CMD_TEXT, 8'hff);
        send_beat(CMD_TEXT, 8'h00);
        send_beat(CMD_END, 8'hff);
        pattern_known = 1'b0;

        while (items_sent < N_ITEMS) begin
            if (items_sent > CALM_AFTER) begin
                tx_idle = 1'b0;
                rx_idle = 1'b0;
            end else begin
                tx_idle = ($urandom_range(0, 3) != 0);
                rx_idle = ($urandom_range(0, 3) != 0);
            end
            if (!long_hold_req && items_sent > 300) begin
                long_hold_req = 1'b1;
                repeat (16) send_beat(CMD_END, 8'($urandom_range(0, 255)));
            end
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 6))
                    send_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
                pattern_known = 1'b0;
            end else begin
                send_sequence();
            end
        end
        s_tvalid <= 1'b0;

        wait (pending == 0);
        repeat (8) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
